### rtl/radix_digit_formatter_macros.svh
// ----------------------------------------------------------------------------
// radix_digit_formatter_macros
// Assertion macros used by the formatter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_FORMATTER_MACROS_SVH
`define RADIX_DIGIT_FORMATTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_digit_formatter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix_digit_formatter: next-cycle check failed");

`endif

### rtl/rdf_pkg.sv
// ----------------------------------------------------------------------------
// rdf_pkg
// Widths, codes and controller/datapath interface types of the formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

   // Value and alphabet geometry.
   localparam int VALUE_BITS  = 32;
   localparam int MAX_RADIX   = 16;
   localparam int LEN_W       = 5;
   localparam int DIGIT_W     = $clog2(MAX_RADIX);
   localparam int BYTE_W      = 8;
   localparam int OUT_SYM_W   = 7;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   // Digit stack holds at most one digit per value bit (radix two).
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

   // The divider retires this many quotient bits per cycle.
   localparam int DIV_BITS    = 4;
   localparam int DIV_STEPS   = VALUE_BITS / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Symbol codes.
   localparam logic [BYTE_W-1:0] SYM_MINUS = 8'd45;
   localparam logic [BYTE_W-1:0] SYM_PLUS  = 8'd43;
   localparam logic [BYTE_W:0]   SYM_LIMIT = 9'd128;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_LEN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new request
      logic check_mode;  // symbol read port addressed by the check index
      logic check_step;  // advance the check index
      logic div_step;    // one divider iteration
      logic div_last;    // final iteration of a digit: push the remainder
      logic emit_sign;   // load '-' into the output register
      logic emit_digit;  // pop a digit into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_bad;
      logic sym_bad;
      logic check_last;
      logic neg;
      logic quot_zero;
      logic out_free;
      logic stack_one;
      logic stack_empty;
   } dp_stat_type;

endpackage

### rtl/rdf_ctrl.sv
// ----------------------------------------------------------------------------
// rdf_ctrl
// Sequencer: alphabet check, digit division loop and symbol emission.
// ----------------------------------------------------------------------------
module rdf_ctrl
   import rdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_DIGIT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 div_last;

   // Only an idle controller takes a new request.
   assign req_stall = (state_ff != ST_IDLE);
   assign div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            div_cnt_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check_mode = 1'b1;
            if (stat.len_bad || stat.sym_bad) begin
               state_in = ST_IDLE;
            end else if (stat.check_last) begin
               state_in = ST_DIVIDE;
            end else begin
               cmd.check_step = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.div_last = div_last;
            div_cnt_in   = div_last ? '0 : div_cnt_ff + 1'b1;
            if (div_last && stat.quot_zero) begin
               state_in = stat.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (stat.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (stat.out_free) begin
               cmd.emit_digit = 1'b1;
               if (stat.stack_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

### rtl/rdf_datapath.sv
// ----------------------------------------------------------------------------
// rdf_datapath
// Configuration registers, alphabet checker, radix divider, digit stack and
// output register.
// ----------------------------------------------------------------------------
module rdf_datapath
   import rdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  ctrl_cmd_type           cmd,
   output dp_stat_type            stat,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [OUT_SYM_W-1:0]   rsp_symbol,
   output logic                   rsp_last
);

   logic [LEN_W-1:0]        radix_len_ff;
   logic [CSR_DATA_W-1:0]   symbols_low_ff;
   logic [CSR_DATA_W-1:0]   symbols_high_ff;
   logic [2*CSR_DATA_W-1:0] symbols_all;

   logic [BYTE_W-1:0]      sym_arr [MAX_RADIX];
   logic [DIGIT_W-1:0]     check_idx_ff, check_idx_in;
   logic [DIGIT_W-1:0]     sym_addr;
   logic [BYTE_W-1:0]      cur_sym;
   logic                   cur_bad;
   logic                   cur_dup;

   logic                   neg_ff;
   logic [VALUE_BITS-1:0]  quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]       part;

   logic [DIGIT_W-1:0]     stack_ff [STACK_DEPTH];
   logic [STACK_CNT_W-1:0] stack_cnt_ff;
   logic [STACK_CNT_W-1:0] stack_top;

   logic                   rsp_valid_ff;
   logic [OUT_SYM_W-1:0]   rsp_symbol_ff;
   logic                   rsp_last_ff;
   logic                   out_free;

   // Configuration writes; indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_len_ff    <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIX_LEN:    radix_len_ff    <= csr_data[LEN_W-1:0];
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Alphabet as an array of bytes, symbol 0 in the low byte.
   assign symbols_all = {symbols_high_ff, symbols_low_ff};

   always_comb begin
      for (int i = 0; i < MAX_RADIX; i++) begin
         sym_arr[i] = symbols_all[i*BYTE_W +: BYTE_W];
      end
   end

   // One symbol read port, shared by the checker and the emitter.
   assign stack_top = stack_cnt_ff - 1'b1;
   assign sym_addr  = cmd.check_mode ? check_idx_ff : stack_ff[stack_top[STACK_IDX_W-1:0]];
   assign cur_sym   = sym_arr[sym_addr];

   // The current symbol is illegal, or equals one of the earlier symbols.
   always_comb begin
      cur_bad = (cur_sym == '0) || ({1'b0, cur_sym} >= SYM_LIMIT) ||
                (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS);
      cur_dup = 1'b0;
      for (int j = 0; j < MAX_RADIX; j++) begin
         if ((DIGIT_W'(j) < check_idx_ff) && (sym_arr[j] == cur_sym)) begin
            cur_dup = 1'b1;
         end
      end
   end

   // Check index walks the alphabet one symbol a cycle.
   always_comb begin
      check_idx_in = check_idx_ff;
      if (cmd.load) begin
         check_idx_in = '0;
      end else if (cmd.check_step) begin
         check_idx_in = check_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      check_idx_ff <= check_idx_in;
   end

   // Restoring division by the radix, several quotient bits per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      part    = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         part    = {rem_in, quot_in[VALUE_BITS-1]};
         quot_in = {quot_in[VALUE_BITS-2:0], 1'b0};
         if (part >= radix_len_ff) begin
            part       = part - radix_len_ff;
            quot_in[0] = 1'b1;
         end
         rem_in = part[DIGIT_W-1:0];
      end
   end

   // Magnitude and sign capture, then the division loop.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= req_value[VALUE_BITS-1];
         quot_ff <= req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= cmd.div_last ? '0 : rem_in;
      end
   end

   // Digit stack: remainders pushed least significant first, popped for output.
   always_ff @(posedge clock) begin
      if (cmd.div_step && cmd.div_last) begin
         stack_ff[stack_cnt_ff[STACK_IDX_W-1:0]] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_cnt_ff <= '0;
      end else if (cmd.load) begin
         stack_cnt_ff <= '0;
      end else if (cmd.div_step && cmd.div_last) begin
         stack_cnt_ff <= stack_cnt_ff + 1'b1;
      end else if (cmd.emit_digit) begin
         stack_cnt_ff <= stack_top;
      end
   end

   // Output register; free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_symbol_ff <= SYM_MINUS[OUT_SYM_W-1:0];
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_symbol_ff <= cur_sym[OUT_SYM_W-1:0];
         rsp_last_ff   <= (stack_cnt_ff == STACK_CNT_W'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // Status to the controller.
   always_comb begin
      stat             = '0;
      stat.len_bad     = (radix_len_ff < LEN_W'(2)) || (radix_len_ff > LEN_W'(MAX_RADIX));
      stat.sym_bad     = cur_bad || cur_dup;
      stat.check_last  = ({1'b0, check_idx_ff} == (radix_len_ff - 1'b1));
      stat.neg         = neg_ff;
      stat.quot_zero   = (quot_in == '0);
      stat.out_free    = out_free;
      stat.stack_one   = (stack_cnt_ff == STACK_CNT_W'(1));
      stat.stack_empty = (stack_cnt_ff == '0);
   end

endmodule

### rtl/radix_digit_formatter.sv
// ----------------------------------------------------------------------------
// radix_digit_formatter
// Formats signed 32-bit integers as text in a configured radix.
// ----------------------------------------------------------------------------
// Each request carries one signed value; the block answers with its text, one
// character per response, most significant digit first, '-' leading for a
// negative value and rsp_last on the final character. The radix is the
// alphabet length register and the digits are the first that many bytes of
// symbols_low/symbols_high. An
// alphabet shorter than two, longer than sixteen, or holding a zero, '+', '-',
// a byte above 127 or a repeated symbol produces no response at all. One
// request is processed at a time: the block captures it, checks the alphabet
// one symbol per cycle, divides by the radix four quotient bits per cycle
// for each digit, and then emits the characters, waiting while the response
// side stalls. The most negative value in radix two gives the longest text:
// 32 digits and a sign.
// Configuration writes are always accepted and must be made while idle.
// ----------------------------------------------------------------------------
`include "radix_digit_formatter_macros.svh"

module radix_digit_formatter
   import rdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_BITS-1:0]  req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_SYM_W-1:0]   rsp_symbol,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   // Sequencer.
   rdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   rdf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   // An accepted request keeps the block busy in the following cycle.
   `RDF_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // A character is never written over one that is still waiting.
   `RDF_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.emit_sign || cmd.emit_digit, !rsp_valid || !rsp_stall)
   // A digit is only popped from a non-empty stack.
   `RDF_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd.emit_digit, !stat.stack_empty)

endmodule
